FILE: hw/rtl/dcifq_pkg.sv
`timescale 1ns / 1ps
// Package for the DC-injection fault qualifier: field widths, register map
// and shared defaults. No dependencies; dcifq_in_if and all modules import it.

package dcifq_pkg;

	// Number of phase current samples carried in one input transaction.
	localparam int NUM_CURRENT_INPUTS = 3;

	// Default number of phases with counter storage.
	localparam int PHASES_DEFAULT = 3;

	localparam int SAMPLE_W    = 16;
	localparam int THRESH_W    = 15;
	localparam int COUNT_W     = 16;
	localparam int CFG_PHASE_W = 2;

	// APB register file: seven 32-bit registers at 4-byte spacing.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [CFG_PHASE_W-1:0] PHASES_IN_USE_RESET = 2'd3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEVEL1_THRESHOLD     = 3'd0,
		REG_LEVEL2_THRESHOLD     = 3'd1,
		REG_RECOVERY_THRESHOLD   = 3'd2,
		REG_LEVEL1_COUNT_LIMIT   = 3'd3,
		REG_LEVEL2_COUNT_LIMIT   = 3'd4,
		REG_RECOVERY_COUNT_LIMIT = 3'd5,
		REG_PHASES_IN_USE        = 3'd6
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: hw/rtl/dcifq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the DC-injection fault qualifier:
// the per-item sample channel and the fault result channel. Uses dcifq_pkg.

interface dcifq_in_if
	import dcifq_pkg::*;
	();
	logic    valid;
	logic    ready;
	sample_t current_phase_a;
	sample_t current_phase_b;
	sample_t current_phase_c;
	logic    mode;

	modport source (output valid, output current_phase_a, output current_phase_b,
		output current_phase_c, output mode, input ready);
	modport sink (input valid, input current_phase_a, input current_phase_b,
		input current_phase_c, input mode, output ready);
endinterface

interface dcifq_out_if;
	logic valid;
	logic ready;
	logic fault;

	modport source (output valid, output fault, input ready);
	modport sink (input valid, input fault, output ready);
endinterface

FILE: hw/rtl/dc_injection_fault_qualifier.sv
`timescale 1ns / 1ps
// An accepted sample transaction passes the input stage and result registers.
// Throughput: one transaction per cycle unless the result is stalled; each
// per-phase counter update is combinational, so items never wait on each other.
// Reset (arst_n low, asynchronous): all counters cleared, registers to defaults
// (phases_in_use = 3, all others 0), both pipeline stages empty.

module dc_injection_fault_qualifier
	import dcifq_pkg::*;
	#(
	parameter int PHASES = PHASES_DEFAULT
	) (
	input  logic                  clk,
	input  logic                  arst_n,
	dcifq_in_if.sink              samples,
	dcifq_out_if.source           result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// Configuration registers
	logic [THRESH_W-1:0]    level1_threshold_q;
	logic [THRESH_W-1:0]    level2_threshold_q;
	logic [THRESH_W-1:0]    recovery_threshold_q;
	count_t                 level1_count_limit_q;
	count_t                 level2_count_limit_q;
	count_t                 recovery_count_limit_q;
	logic [CFG_PHASE_W-1:0] phases_in_use_q;

	cfg_reg_t reg_idx;
	logic     cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level1_threshold_q     <= '0;
			level2_threshold_q     <= '0;
			recovery_threshold_q   <= '0;
			level1_count_limit_q   <= '0;
			level2_count_limit_q   <= '0;
			recovery_count_limit_q <= '0;
			phases_in_use_q        <= PHASES_IN_USE_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_LEVEL1_THRESHOLD:     level1_threshold_q     <= pwdata[THRESH_W-1:0];
				REG_LEVEL2_THRESHOLD:     level2_threshold_q     <= pwdata[THRESH_W-1:0];
				REG_RECOVERY_THRESHOLD:   recovery_threshold_q   <= pwdata[THRESH_W-1:0];
				REG_LEVEL1_COUNT_LIMIT:   level1_count_limit_q   <= pwdata[COUNT_W-1:0];
				REG_LEVEL2_COUNT_LIMIT:   level2_count_limit_q   <= pwdata[COUNT_W-1:0];
				REG_RECOVERY_COUNT_LIMIT: recovery_count_limit_q <= pwdata[COUNT_W-1:0];
				REG_PHASES_IN_USE:        phases_in_use_q        <= pwdata[CFG_PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LEVEL1_THRESHOLD:     prdata = APB_DATA_W'(level1_threshold_q);
			REG_LEVEL2_THRESHOLD:     prdata = APB_DATA_W'(level2_threshold_q);
			REG_RECOVERY_THRESHOLD:   prdata = APB_DATA_W'(recovery_threshold_q);
			REG_LEVEL1_COUNT_LIMIT:   prdata = APB_DATA_W'(level1_count_limit_q);
			REG_LEVEL2_COUNT_LIMIT:   prdata = APB_DATA_W'(level2_count_limit_q);
			REG_RECOVERY_COUNT_LIMIT: prdata = APB_DATA_W'(recovery_count_limit_q);
			REG_PHASES_IN_USE:        prdata = APB_DATA_W'(phases_in_use_q);
			default:                  prdata = '0;
		endcase
	end

	// Input stage
	logic    valid_s1;
	sample_t cur_s1 [NUM_CURRENT_INPUTS];
	logic    mode_s1;
	logic    advance;
	logic    out_valid_q;
	logic    fault_q;

	// The result register frees up when empty or being taken this cycle.
	assign advance       = valid_s1 && (!out_valid_q || result.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			cur_s1[0] <= samples.current_phase_a;
			cur_s1[1] <= samples.current_phase_b;
			cur_s1[2] <= samples.current_phase_c;
			mode_s1   <= samples.mode;
		end
	end

	// Per-phase magnitude tests. Magnitude is kept 16 bits unsigned, so the
	// most negative sample gives 32768 and exceeds every threshold.
	count_t level1_cnt_q [PHASES];
	count_t level2_cnt_q [PHASES];
	count_t level1_cnt_n [PHASES];
	count_t level2_cnt_n [PHASES];
	count_t level1_inc   [PHASES];
	count_t level2_inc   [PHASES];
	logic [PHASES-1:0] active;
	logic [PHASES-1:0] over1;
	logic [PHASES-1:0] over2;
	logic [PHASES-1:0] over_rec;

	for (genvar P = 0; P < PHASES; P++) begin : g_phase
		assign level1_inc[P] = level1_cnt_q[P] + 1'b1;
		assign level2_inc[P] = level2_cnt_q[P] + 1'b1;
		if (P < NUM_CURRENT_INPUTS) begin : g_used
			logic [SAMPLE_W-1:0] mag;
			assign mag         = cur_s1[P][SAMPLE_W-1] ? SAMPLE_W'(-cur_s1[P])
				: SAMPLE_W'(cur_s1[P]);
			assign active[P]   = phases_in_use_q > CFG_PHASE_W'(P);
			assign over1[P]    = mag > {1'b0, level1_threshold_q};
			assign over2[P]    = mag > {1'b0, level2_threshold_q};
			assign over_rec[P] = mag > {1'b0, recovery_threshold_q};
		end else begin : g_unused
			assign active[P]   = 1'b0;
			assign over1[P]    = 1'b0;
			assign over2[P]    = 1'b0;
			assign over_rec[P] = 1'b0;
		end
	end

	// Normal mode: phases in order; the first one to reach its limit stops
	// the chain and the phases after it keep their counts.
	logic normal_fault;

	always_comb begin
		logic done;
		done         = 1'b0;
		normal_fault = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			level1_cnt_n[p] = level1_cnt_q[p];
			level2_cnt_n[p] = level2_cnt_q[p];
			if (!done && active[p]) begin
				if (over2[p]) begin
					level1_cnt_n[p] = level1_inc[p];
					level2_cnt_n[p] = level2_inc[p];
					if (level2_inc[p] >= level2_count_limit_q) begin
						level1_cnt_n[p] = '0;
						level2_cnt_n[p] = '0;
						done            = 1'b1;
					end
				end else if (over1[p]) begin
					level1_cnt_n[p] = level1_inc[p];
					level2_cnt_n[p] = '0;
					if (level1_inc[p] >= level1_count_limit_q) begin
						level1_cnt_n[p] = '0;
						done            = 1'b1;
					end
				end else begin
					level1_cnt_n[p] = '0;
					level2_cnt_n[p] = '0;
				end
			end
		end
		normal_fault = done;
	end

	// Recovery mode: any loud active phase restarts the quiet count.
	count_t recovery_cnt_q;
	count_t recovery_next;
	logic   recovery_done;

	assign recovery_next = (|(over_rec & active) ? count_t'(0) : recovery_cnt_q) + 1'b1;
	assign recovery_done = recovery_next >= recovery_count_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PHASES; p++) begin
				level1_cnt_q[p] <= '0;
				level2_cnt_q[p] <= '0;
			end
			recovery_cnt_q <= '0;
		end else if (advance) begin
			if (mode_s1) begin
				recovery_cnt_q <= recovery_done ? count_t'(0) : recovery_next;
			end else begin
				level1_cnt_q <= level1_cnt_n;
				level2_cnt_q <= level2_cnt_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fault_q <= mode_s1 ? !recovery_done : normal_fault;
		end
	end

	assign result.valid = out_valid_q;
	assign result.fault = fault_q;

endmodule

FILE: hw/rtl/dcifq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the DC-injection fault qualifier, bound to the top
// level. Depends on dcifq_pkg and the dc_injection_fault_qualifier ports.

module dcifq_checker
	import dcifq_pkg::*;
	(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_fault,
	input logic pready
);

	// A stalled result keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_fault))
		else $error("result changed or dropped while stalled");

	// The sample side only backs up when a result is waiting and refused.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A result that appears after an empty output comes from the transaction
	// that was held in the input stage register ahead of the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching accepted transaction");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready deasserted");

endmodule

bind dc_injection_fault_qualifier dcifq_checker u_dcifq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_fault (result.fault),
	.pready    (pready)
);
